// ===== src/tpq_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and the fixed priority table of the typed priority task queue
// no dependencies
package tpq_pkg;

  localparam int TYPE_W = 4;
  localparam int PRIO_W = 9;

  localparam logic [TYPE_W-1:0] TYPE_MESSAGE = 4'd4;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_REPLACE = 2'd1,
    FUNC_POP     = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_INS,
    S_HEAD,
    S_DONE
  } state_t;

  // lower number leaves first; type 0 and the unused type 15 share the lowest rank
  function automatic logic [PRIO_W-1:0] prio_of(input logic [TYPE_W-1:0] t);
    logic [PRIO_W-1:0] p;
    case (t)
      4'd0, 4'd15: p = 9'd256;
      4'd1, 4'd2:  p = 9'd0;
      4'd3:        p = 9'd1;
      4'd4, 4'd5:  p = 9'd2;
      4'd6:        p = 9'd255;
      4'd13:       p = 9'd20;
      default:     p = 9'd10;
    endcase
    return p;
  endfunction

endpackage

// ===== src/tpq_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module tpq_ram #(
  parameter int WIDTH = 45,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/typed_priority_task_queue_core.sv =====
`timescale 1ns / 1ps
// Typed priority task queue, top level. Entries sit in one ram, sorted by the priority of
// their type, head at address 0. An item is accepted, walks the ram entries it needs, then
// the head is read and the result loaded: a push walks from the tail down to its insertion
// point, a pop walks every entry, a replace with a payload rewrites the head payload, and a
// push into an empty queue writes the head directly. Entries move one at a time, read then
// written back through the ram. One item is worked on at a time; a finished result waits
// in the output register while the next item is accepted. Depends on tpq_pkg and tpq_ram.
module typed_priority_task_queue_core
  import tpq_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PAYLOAD_WIDTH = 32,
  localparam int OCC_W        = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_W         = TYPE_W + PAYLOAD_WIDTH,
  localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W        = TYPE_W + PAYLOAD_WIDTH + 4 + OCC_W,
  localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // task_type, payload
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // func, payload_present
  input  logic [2:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // head_type, head_payload, queue_empty, notify_new_task, status, occupancy_out
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int ENTRY_W = TYPE_W + PRIO_W + PAYLOAD_WIDTH;
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

  state_t state, state_next;

  logic [OCC_W-1:0]         occupancy;
  logic [IDX_W-1:0]         idx;
  func_t                    op_func;
  logic [TYPE_W-1:0]        op_type;
  logic [PAYLOAD_WIDTH-1:0] op_payload;
  logic                     op_present;
  status_t                  op_status;
  logic                     op_notify;

  logic                     out_valid;
  logic [TYPE_W-1:0]        out_type;
  logic [PAYLOAD_WIDTH-1:0] out_payload;
  logic                     out_empty;
  logic                     out_notify;
  status_t                  out_status;
  logic [OCC_W-1:0]         out_occ;

  logic                     ram_wr_en;
  logic [IDX_W-1:0]         ram_wr_addr;
  logic [ENTRY_W-1:0]       ram_wr_data;
  logic                     ram_rd_en;
  logic [IDX_W-1:0]         ram_rd_addr;
  logic [ENTRY_W-1:0]       ram_rd_data;

  func_t                    in_func;
  logic                     in_present;
  logic [TYPE_W-1:0]        in_type;
  logic                     accept;
  logic                     out_free;
  logic [TYPE_W-1:0]        rd_type;
  logic [PRIO_W-1:0]        rd_prio;
  logic [PRIO_W-1:0]        op_prio;
  logic [ENTRY_W-1:0]       new_entry;
  logic                     rd_lower;
  logic                     idx_last;

  tpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_func    = func_t'(s_tuser[1:0]);
  assign in_present = s_tuser[2];
  assign in_type    = s_tdata[TYPE_W-1:0];
  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !out_valid || m_tready;

  assign rd_type   = ram_rd_data[ENTRY_W-1 -: TYPE_W];
  assign rd_prio   = ram_rd_data[PAYLOAD_WIDTH +: PRIO_W];
  assign op_prio   = prio_of(op_type);
  assign new_entry = {op_type, op_prio, (op_present ? op_payload : '0)};
  // entry read from the tail side must move up one place to make room
  assign rd_lower  = rd_prio > op_prio;
  assign idx_last  = (OCC_W'(idx) == occupancy - 1'b1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (in_func)
            FUNC_PUSH: begin
              if (occupancy == OCC_FULL) begin
                state_next = S_HEAD;
              end else if (occupancy == '0) begin
                state_next = S_INS;
              end else begin
                state_next = S_RD;
              end
            end
            FUNC_REPLACE: begin
              state_next = (occupancy != '0 && in_present) ? S_RD : S_HEAD;
            end
            FUNC_POP: begin
              state_next = (occupancy != '0) ? S_RD : S_HEAD;
            end
            default: state_next = S_HEAD;
          endcase
        end
      end
      S_RD: state_next = S_WR;
      S_WR: begin
        case (op_func)
          FUNC_PUSH: begin
            if (!rd_lower) begin
              state_next = S_HEAD;
            end else if (idx == '0) begin
              state_next = S_INS;
            end else begin
              state_next = S_RD;
            end
          end
          FUNC_POP: state_next = idx_last ? S_HEAD : S_RD;
          default:  state_next = S_HEAD;
        endcase
      end
      S_INS:  state_next = S_HEAD;
      S_HEAD: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = new_entry;
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    case (state)
      S_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = idx;
      end
      S_WR: begin
        case (op_func)
          FUNC_PUSH: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx + 1'b1;
            ram_wr_data = rd_lower ? ram_rd_data : new_entry;
          end
          FUNC_POP: begin
            ram_wr_en   = (idx != '0);
            ram_wr_addr = idx - 1'b1;
            ram_wr_data = ram_rd_data;
          end
          FUNC_REPLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = '0;
            ram_wr_data = {ram_rd_data[ENTRY_W-1:PAYLOAD_WIDTH], op_payload};
          end
          default: ram_wr_en = 1'b0;
        endcase
      end
      S_INS: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = '0;
      end
      S_HEAD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = '0;
      end
      default: ram_rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_WR: begin
          if (op_func == FUNC_PUSH && !rd_lower) begin
            occupancy <= occupancy + 1'b1;
          end
          if (op_func == FUNC_POP && idx_last) begin
            occupancy <= occupancy - 1'b1;
          end
        end
        S_INS: occupancy <= occupancy + 1'b1;
        default: ;
      endcase
    end
  end

  // item latch, walk index and result register
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op_func    <= in_func;
          op_type    <= in_type;
          op_present <= in_present;
          op_payload <= s_tdata[TYPE_W +: PAYLOAD_WIDTH];
          op_notify  <= 1'b0;
          // a push walks down from the tail, a pop walks up from the head
          idx        <= (in_func == FUNC_PUSH) ? IDX_W'(occupancy - 1'b1) : '0;
          if (in_func == FUNC_PUSH && occupancy == OCC_FULL) begin
            op_status <= ST_FULL;
          end else if ((in_func == FUNC_POP || in_func == FUNC_REPLACE) && occupancy == '0) begin
            op_status <= ST_EMPTY;
          end else begin
            op_status <= ST_OK;
          end
        end
      end
      S_WR: begin
        if (op_func == FUNC_PUSH && rd_lower && idx != '0) begin
          idx <= idx - 1'b1;
        end
        if (op_func == FUNC_POP) begin
          if (idx == '0) begin
            op_notify <= (rd_type != TYPE_MESSAGE);
          end
          if (!idx_last) begin
            idx <= idx + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_type    <= (occupancy == '0) ? '0 : rd_type;
          out_payload <= (occupancy == '0) ? '0 : ram_rd_data[PAYLOAD_WIDTH-1:0];
          out_empty   <= (occupancy == '0);
          out_notify  <= op_notify;
          out_status  <= op_status;
          out_occ     <= occupancy;
        end
      end
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'({out_occ, out_status, out_notify, out_empty,
                                  out_payload, out_type});

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_FULL)
    else $error("occupancy above queue depth");

  a_notify_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_notify || out_status == ST_OK))
    else $error("notify raised on a failed item");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_empty == (out_occ == '0)))
    else $error("empty flag disagrees with occupancy");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!ram_wr_en && !ram_rd_en))
    else $error("ram access while idle");

  a_full_no_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && in_func == FUNC_PUSH && occupancy == OCC_FULL) |=> (occupancy == OCC_FULL))
    else $error("dropped push changed occupancy");
`endif

endmodule
